[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, clocked on the rising edge, off while reset is high.
`define SPFS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Overlapping implication.
`define SPFS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication.
`define SPFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[hdl/spfs_pkg.sv]
// ---------------------------------------------------------------------------
// spfs_pkg
// Widths, codes and defaults of the sprite frame sequencer.
// ---------------------------------------------------------------------------
package spfs_pkg;

  localparam int MAX_FRAMES_DEF     = 256;
  localparam int FRAME_DIM_BITS_DEF = 10;

  localparam int KIND_W     = 2;
  localparam int ELAPSED_W  = 10;
  localparam int FRAME_W    = 8;
  localparam int CNT_W      = FRAME_W + 1;
  localparam int CUR_W      = CNT_W + 2;
  localparam int COLS_W     = 8;
  localparam int PERIOD_W   = 16;
  localparam int ACC_W      = 17;
  localparam int RECT_W     = 18;
  localparam int RECT_END_W = 19;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_COLUMNS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FRAME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_FRAME    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PING_PONG     = 3'd6;

  localparam int FRAME_DIM_RESET = 16;
  localparam int COLS_RESET      = 1;
  localparam int PERIOD_RESET    = 100;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

endpackage

[hdl/sprite_frame_sequencer_top.sv]
// ---------------------------------------------------------------------------
// sprite_frame_sequencer_top
// Sprite-sheet animation stepper with a serial divider for the source rectangle.
// ---------------------------------------------------------------------------
// One item is taken at a time. An advancing tick passes ST_CHECK to step the
// frame, ST_MOD to wrap it modulo MAX_FRAMES with a constant reciprocal
// multiply, 9 passes of ST_RDIV through the shared restoring divider (frame
// over sheet_columns), ST_MUL_TOP and ST_MUL_LEFT on the shared multiplier
// for top and left, and ST_DONE to load the output register. A tick that
// does not advance goes from ST_CHECK to ST_DONE; a set-frame, a restart or
// an unused kind goes from ST_IDLE to ST_DONE. The block takes the next item
// in the cycle after the result loads, even while that result waits; a
// result still waiting when the next one is ready holds the block.
module sprite_frame_sequencer_top #(
  parameter int MAX_FRAMES     = spfs_pkg::MAX_FRAMES_DEF,
  parameter int FRAME_DIM_BITS = spfs_pkg::FRAME_DIM_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [spfs_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [spfs_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [spfs_pkg::KIND_W-1:0]      kind,
  input  logic [spfs_pkg::ELAPSED_W-1:0]   elapsed_ms,
  input  logic [spfs_pkg::FRAME_W-1:0]     frame_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [spfs_pkg::FRAME_W-1:0]     current_frame,
  output logic                             advanced,
  output logic [spfs_pkg::RECT_W-1:0]      rect_top,
  output logic [spfs_pkg::RECT_W-1:0]      rect_left,
  output logic [spfs_pkg::RECT_END_W-1:0]  rect_bottom,
  output logic [spfs_pkg::RECT_END_W-1:0]  rect_right
);

  localparam int DIM_W   = (FRAME_DIM_BITS > 5) ? FRAME_DIM_BITS : 5;
  localparam int DVS_W   = spfs_pkg::COLS_W;
  localparam int STEP_W  = $clog2(spfs_pkg::CNT_W);
  localparam int PROD_W  = spfs_pkg::CNT_W + DIM_W;
  localparam int CNT_W   = spfs_pkg::CNT_W;
  localparam int CUR_W   = spfs_pkg::CUR_W;
  localparam int FRAME_W = spfs_pkg::FRAME_W;
  localparam int MOD_L   = $clog2(MAX_FRAMES);
  localparam int MOD_S   = CNT_W + MOD_L;
  localparam int MOD_M   = ((2 ** MOD_S) + MAX_FRAMES - 1) / MAX_FRAMES;
  localparam int MOD_P_W = 2 * CNT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOD,
    ST_RDIV,
    ST_MUL_TOP,
    ST_MUL_LEFT,
    ST_DONE
  } state_t;

  state_t state;

  logic [DIM_W-1:0]              frame_width;
  logic [DIM_W-1:0]              frame_height;
  logic [spfs_pkg::COLS_W-1:0]   sheet_columns;
  logic [FRAME_W-1:0]            first_frame;
  logic [FRAME_W-1:0]            last_frame;
  logic [spfs_pkg::PERIOD_W-1:0] frame_period;
  logic                          ping_pong;

  logic [CNT_W-1:0]              frame_counter;
  logic [spfs_pkg::ACC_W-1:0]    time_accumulator;
  logic                          moving_backward;
  logic [spfs_pkg::RECT_W-1:0]   source_top;
  logic [spfs_pkg::RECT_W-1:0]   source_left;
  logic                          adv_flag;

  logic [CNT_W-1:0]              div_q;
  logic [DVS_W:0]                div_rem;
  logic [STEP_W-1:0]             div_step;

  // Saturating accumulate
  logic [spfs_pkg::ACC_W:0]      acc_sum;
  logic [spfs_pkg::ACC_W-1:0]    acc_next;

  always_comb begin
    acc_sum  = {1'b0, time_accumulator} + (spfs_pkg::ACC_W + 1)'(elapsed_ms);
    acc_next = acc_sum[spfs_pkg::ACC_W] ? spfs_pkg::ACC_MAX
                                        : acc_sum[spfs_pkg::ACC_W-1:0];
  end

  // Frame step
  logic signed [CUR_W-1:0] cur;
  logic signed [CUR_W-1:0] lo_s;
  logic signed [CUR_W-1:0] hi_s;
  logic                    dir_next;

  always_comb begin
    lo_s     = $signed(CUR_W'(first_frame));
    hi_s     = $signed(CUR_W'(last_frame));
    dir_next = moving_backward;
    cur      = $signed(CUR_W'(frame_counter));
    if (!ping_pong) begin
      cur = cur + CUR_W'(1);
      if (cur > hi_s) begin
        cur = lo_s;
      end
    end else begin
      cur = moving_backward ? cur - CUR_W'(1) : cur + CUR_W'(1);
      if (cur > hi_s) begin
        cur      = hi_s - CUR_W'(1);
        dir_next = ~dir_next;
      end
      if (cur < lo_s) begin
        cur      = lo_s + CUR_W'(1);
        dir_next = ~dir_next;
      end
    end
    if (cur < 0) begin
      cur = '0;
    end
  end

  // Wrap modulo MAX_FRAMES: quotient by reciprocal multiply, exact for any frame
  logic [MOD_P_W-1:0] mod_prod;
  logic [CNT_W-1:0]   mod_q;
  logic [CNT_W-1:0]   mod_rem;

  always_comb begin
    mod_prod = MOD_P_W'(div_q) * MOD_P_W'(MOD_M);
    mod_q    = CNT_W'(mod_prod >> MOD_S);
    mod_rem  = CNT_W'(MOD_P_W'(div_q) - MOD_P_W'(mod_q) * MOD_P_W'(MAX_FRAMES));
  end

  // Shared restoring divide step
  logic [DVS_W-1:0] divisor;
  logic [DVS_W:0]   div_shift;
  logic             div_ge;
  logic [DVS_W:0]   div_rem_next;
  logic [CNT_W-1:0] div_q_next;

  always_comb begin
    divisor      = (sheet_columns == '0) ? DVS_W'(1) : DVS_W'(sheet_columns);
    div_shift    = {div_rem[DVS_W-1:0], div_q[CNT_W-1]};
    div_ge       = div_shift >= {1'b0, divisor};
    div_rem_next = div_ge ? div_shift - {1'b0, divisor} : div_shift;
    div_q_next   = {div_q[CNT_W-2:0], div_ge};
  end

  // Shared multiplier
  logic [CNT_W-1:0]  mul_a;
  logic [DIM_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;

  always_comb begin
    if (state == ST_MUL_TOP) begin
      mul_a = div_q;
      mul_b = frame_height;
    end else begin
      mul_a = div_rem[CNT_W-1:0];
      mul_b = frame_width;
    end
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  logic set_in_range;
  assign set_in_range = !(frame_index < first_frame || frame_index > last_frame);

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      frame_width      <= DIM_W'(spfs_pkg::FRAME_DIM_RESET);
      frame_height     <= DIM_W'(spfs_pkg::FRAME_DIM_RESET);
      sheet_columns    <= spfs_pkg::COLS_W'(spfs_pkg::COLS_RESET);
      first_frame      <= '0;
      last_frame       <= '0;
      frame_period     <= spfs_pkg::PERIOD_W'(spfs_pkg::PERIOD_RESET);
      ping_pong        <= 1'b0;
      frame_counter    <= '0;
      time_accumulator <= '0;
      moving_backward  <= 1'b0;
      source_top       <= '0;
      source_left      <= '0;
      adv_flag         <= 1'b0;
      div_step         <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          spfs_pkg::REG_FRAME_WIDTH:
            frame_width <= DIM_W'(cfg_wr_data[FRAME_DIM_BITS-1:0]);
          spfs_pkg::REG_FRAME_HEIGHT:
            frame_height <= DIM_W'(cfg_wr_data[FRAME_DIM_BITS-1:0]);
          spfs_pkg::REG_SHEET_COLUMNS: sheet_columns <= cfg_wr_data[spfs_pkg::COLS_W-1:0];
          spfs_pkg::REG_FIRST_FRAME:   first_frame   <= cfg_wr_data[FRAME_W-1:0];
          spfs_pkg::REG_LAST_FRAME:    last_frame    <= cfg_wr_data[FRAME_W-1:0];
          spfs_pkg::REG_FRAME_PERIOD:  frame_period  <= cfg_wr_data[spfs_pkg::PERIOD_W-1:0];
          spfs_pkg::REG_PING_PONG:     ping_pong     <= cfg_wr_data[0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            adv_flag <= 1'b0;
            case (kind)
              spfs_pkg::KIND_TICK: begin
                time_accumulator <= acc_next;
                state            <= ST_CHECK;
              end
              spfs_pkg::KIND_SET: begin
                frame_counter <= set_in_range ? CNT_W'(frame_index) : '0;
                state         <= ST_DONE;
              end
              spfs_pkg::KIND_RESTART: begin
                frame_counter    <= '0;
                time_accumulator <= '0;
                moving_backward  <= 1'b0;
                source_top       <= '0;
                source_left      <= '0;
                state            <= ST_DONE;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_CHECK: begin
          if (time_accumulator > spfs_pkg::ACC_W'(frame_period)) begin
            moving_backward  <= dir_next;
            time_accumulator <= '0;
            adv_flag         <= 1'b1;
            div_q            <= cur[CNT_W-1:0];
            div_rem          <= '0;
            div_step         <= '0;
            state            <= ST_MOD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_MOD: begin
          frame_counter <= mod_rem;
          div_q         <= mod_rem;
          div_rem       <= '0;
          div_step      <= '0;
          state         <= ST_RDIV;
        end
        ST_RDIV: begin
          div_q    <= div_q_next;
          div_rem  <= div_rem_next;
          div_step <= div_step + STEP_W'(1);
          if (div_step == STEP_W'(CNT_W - 1)) begin
            state <= ST_MUL_TOP;
          end
        end
        ST_MUL_TOP: begin
          source_top <= spfs_pkg::RECT_W'(mul_p);
          state      <= ST_MUL_LEFT;
        end
        ST_MUL_LEFT: begin
          source_left <= spfs_pkg::RECT_W'(mul_p);
          state       <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            current_frame <= frame_counter[FRAME_W-1:0];
            advanced      <= adv_flag;
            rect_top      <= source_top;
            rect_left     <= source_left;
            rect_bottom   <= {1'b0, source_top} + spfs_pkg::RECT_END_W'(frame_height);
            rect_right    <= {1'b0, source_left} + spfs_pkg::RECT_END_W'(frame_width);
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/spfs_checker.sv]
// ---------------------------------------------------------------------------
// spfs_checker
// Port-level checks of the sprite frame sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spfs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [spfs_pkg::FRAME_W-1:0]     current_frame,
  input logic                             advanced,
  input logic [spfs_pkg::RECT_W-1:0]      rect_top,
  input logic [spfs_pkg::RECT_W-1:0]      rect_left,
  input logic [spfs_pkg::RECT_END_W-1:0]  rect_bottom,
  input logic [spfs_pkg::RECT_END_W-1:0]  rect_right
);

  // Stalled result beat holds
  `SPFS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `SPFS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(current_frame) && $stable(advanced) && $stable(rect_top) && $stable(rect_left))

  // Busy after an accepted beat
  `SPFS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // Rectangle ends never lie before its origin
  `SPFS_ASSERT_IMPL(a_rect_order, clk, rst, out_valid, ({1'b0, rect_top} <= rect_bottom) && ({1'b0, rect_left} <= rect_right))

endmodule

bind sprite_frame_sequencer_top spfs_checker u_spfs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .current_frame (current_frame),
  .advanced      (advanced),
  .rect_top      (rect_top),
  .rect_left     (rect_left),
  .rect_bottom   (rect_bottom),
  .rect_right    (rect_right)
);

[test/sprite_frame_sequencer_top_tb.sv]
// ---------------------------------------------------------------------------
// sprite_frame_sequencer_top_tb
// Self-checking bench for the sprite frame sequencer. A short table of
// directed beats and register writes runs first. Randomized register
// settings and item streams follow. Each result beat is checked against its
// pinned result or an in-bench model of counter, accumulator and rectangle.
// ---------------------------------------------------------------------------
module sprite_frame_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spfs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 30;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_ITEMS   = 45;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [FRAME_W-1:0]    frame;
    logic                  adv;
    logic [RECT_W-1:0]     top;
    logic [RECT_W-1:0]     left;
    logic [RECT_END_W-1:0] bottom;
    logic [RECT_END_W-1:0] right;
  } frame_rect_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e             row;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]      reg_val;
    logic [KIND_W-1:0]     k;
    logic [ELAPSED_W-1:0]  ms;
    logic [FRAME_W-1:0]    idx;
    bit                    pinned;
    frame_rect_t           res;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_W-1:0]      cfg_wr_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [KIND_W-1:0]     kind;
  logic [ELAPSED_W-1:0]  elapsed_ms;
  logic [FRAME_W-1:0]    frame_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [FRAME_W-1:0]    current_frame;
  logic                  advanced;
  logic [RECT_W-1:0]     rect_top;
  logic [RECT_W-1:0]     rect_left;
  logic [RECT_END_W-1:0] rect_bottom;
  logic [RECT_END_W-1:0] rect_right;

  // known result that travels with a directed beat
  bit          pin_on;
  frame_rect_t pin_res;

  // mirrored registers
  logic [FRAME_DIM_BITS_DEF-1:0] width_r;
  logic [FRAME_DIM_BITS_DEF-1:0] height_r;
  logic [COLS_W-1:0]             cols_r;
  logic [FRAME_W-1:0]            first_r;
  logic [FRAME_W-1:0]            last_r;
  logic [PERIOD_W-1:0]           period_r;
  logic                          pp_r;

  // sequencer state
  logic [FRAME_W-1:0] frame_r;
  logic [ACC_W-1:0]   acc_r;
  logic               backward_r;
  logic [RECT_W-1:0]  top_r;
  logic [RECT_W-1:0]  left_r;

  frame_rect_t frame_rect_q[$];
  int          mismatch_cnt = 0;
  int          burst_left = 0;

  sprite_frame_sequencer_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .elapsed_ms    (elapsed_ms),
    .frame_index   (frame_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .current_frame (current_frame),
    .advanced      (advanced),
    .rect_top      (rect_top),
    .rect_left     (rect_left),
    .rect_bottom   (rect_bottom),
    .rect_right    (rect_right)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_sequencer();
    frame_r    = '0;
    acc_r      = '0;
    backward_r = 1'b0;
    top_r      = '0;
    left_r     = '0;
  endfunction

  function automatic frame_rect_t sequence_frame(logic [KIND_W-1:0] k,
                                                 logic [ELAPSED_W-1:0] ms,
                                                 logic [FRAME_W-1:0] idx);
    int          cur;
    int unsigned sum;
    int unsigned cols;
    frame_rect_t r;
    r.adv = 1'b0;
    case (k)
      KIND_TICK: begin
        sum   = acc_r + ms;
        acc_r = (sum > ACC_MAX) ? ACC_MAX : ACC_W'(sum);
        if (acc_r > period_r) begin
          cur = frame_r;
          if (!pp_r) begin
            cur++;
            if (cur > int'(last_r)) cur = first_r;
          end else begin
            cur += backward_r ? -1 : 1;
            if (cur > int'(last_r)) begin
              cur        = int'(last_r) - 1;
              backward_r = ~backward_r;
            end
            if (cur < int'(first_r)) begin
              cur        = int'(first_r) + 1;
              backward_r = ~backward_r;
            end
          end
          if (cur < 0) cur = 0;
          frame_r = FRAME_W'(cur % MAX_FRAMES_DEF);
          cols    = (cols_r == 0) ? 1 : cols_r;
          top_r   = RECT_W'((32'(frame_r) / cols) * 32'(height_r));
          left_r  = RECT_W'((32'(frame_r) % cols) * 32'(width_r));
          acc_r   = '0;
          r.adv   = 1'b1;
        end
      end
      KIND_SET: begin
        frame_r = (idx < first_r || idx > last_r) ? '0 : idx;
      end
      KIND_RESTART: begin
        restart_sequencer();
      end
      default: ;
    endcase
    r.frame  = frame_r;
    r.top    = top_r;
    r.left   = left_r;
    r.bottom = RECT_END_W'(32'(top_r) + 32'(height_r));
    r.right  = RECT_END_W'(32'(left_r) + 32'(width_r));
    return r;
  endfunction

  always @(posedge clk) begin
    frame_rect_t want;
    if (rst) begin
      width_r  = FRAME_DIM_BITS_DEF'(FRAME_DIM_RESET);
      height_r = FRAME_DIM_BITS_DEF'(FRAME_DIM_RESET);
      cols_r   = COLS_W'(COLS_RESET);
      first_r  = '0;
      last_r   = '0;
      period_r = PERIOD_W'(PERIOD_RESET);
      pp_r     = 1'b0;
      restart_sequencer();
      frame_rect_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (frame_rect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: result beat with nothing pending, frame %0d", $time, current_frame);
        end else begin
          want = frame_rect_q.pop_front();
          if (current_frame !== want.frame || advanced !== want.adv ||
              rect_top !== want.top || rect_left !== want.left ||
              rect_bottom !== want.bottom || rect_right !== want.right) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $write("%0t: exp/act frame %0d/%0d adv %0b/%0b top %0d/%0d ", $time,
                     want.frame, current_frame, want.adv, advanced, want.top, rect_top);
              $display("left %0d/%0d bottom %0d/%0d right %0d/%0d",
                       want.left, rect_left, want.bottom, rect_bottom,
                       want.right, rect_right);
            end
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_FRAME_WIDTH:   width_r  = cfg_wr_data[FRAME_DIM_BITS_DEF-1:0];
          REG_FRAME_HEIGHT:  height_r = cfg_wr_data[FRAME_DIM_BITS_DEF-1:0];
          REG_SHEET_COLUMNS: cols_r   = cfg_wr_data[COLS_W-1:0];
          REG_FIRST_FRAME:   first_r  = cfg_wr_data[FRAME_W-1:0];
          REG_LAST_FRAME:    last_r   = cfg_wr_data[FRAME_W-1:0];
          REG_FRAME_PERIOD:  period_r = cfg_wr_data[PERIOD_W-1:0];
          REG_PING_PONG:     pp_r     = cfg_wr_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = sequence_frame(kind, elapsed_ms, frame_index);
        frame_rect_q.push_back(pin_on ? pin_res : want);
      end
    end
  end

  // receiver: runs of full throughput, random stalls and long holds
  initial begin
    int mode;
    int len;
    forever begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(1, 30);
      repeat (len) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic stim_row_t item_row(logic [KIND_W-1:0] k, logic [ELAPSED_W-1:0] ms,
                                         logic [FRAME_W-1:0] idx);
    stim_row_t s;
    s.row     = ROW_ITEM;
    s.reg_idx = REG_FRAME_WIDTH;
    s.reg_val = '0;
    s.k       = k;
    s.ms      = ms;
    s.idx     = idx;
    s.pinned  = 1'b0;
    s.res     = '0;
    return s;
  endfunction

  function automatic stim_row_t pinned_row(logic [KIND_W-1:0] k, int ms, int idx, int fr,
                                           int adv, int top, int left, int bot, int rgt);
    stim_row_t s;
    s        = item_row(k, ELAPSED_W'(ms), FRAME_W'(idx));
    s.pinned = 1'b1;
    s.res    = '{FRAME_W'(fr), 1'(adv), RECT_W'(top), RECT_W'(left),
                 RECT_END_W'(bot), RECT_END_W'(rgt)};
    return s;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] a, int d);
    stim_row_t s;
    s         = item_row(KIND_TICK, '0, '0);
    s.row     = ROW_REG;
    s.reg_idx = a;
    s.reg_val = CFG_W'(d);
    return s;
  endfunction

  task automatic send_item(stim_row_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    kind        <= s.k;
    elapsed_ms  <= s.ms;
    frame_index <= s.idx;
    pin_on      <= s.pinned;
    pin_res     <= s.res;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // hold the sender until every pending result beat is out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (frame_rect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] a, logic [CFG_W-1:0] d);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= a;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    stim_row_t         rows[$];
    stim_row_t         s;
    int                width_v, height_v, cols_v, first_v, last_v, period_v, pp_v;
    int                span, r;
    logic [KIND_W-1:0] k;
    int                ms, idx;

    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_addr    <= REG_FRAME_WIDTH;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    kind        <= KIND_TICK;
    elapsed_ms  <= '0;
    frame_index <= '0;
    pin_on      <= 1'b0;
    pin_res     <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset: one-frame range, 16x16 frames, period 100
    rows.push_back(pinned_row(KIND_TICK, 100, 0, 0, 0, 0, 0, 16, 16));
    rows.push_back(pinned_row(KIND_TICK, 1, 0, 0, 1, 0, 0, 16, 16));
    rows.push_back(pinned_row(KIND_UNUSED, 1023, 255, 0, 0, 0, 0, 16, 16));
    rows.push_back(pinned_row(KIND_SET, 0, 255, 0, 0, 0, 0, 16, 16));
    rows.push_back(pinned_row(KIND_RESTART, 1023, 255, 0, 0, 0, 0, 16, 16));
    // largest frames, full range, advance on any nonzero tick
    rows.push_back(reg_row(REG_FRAME_WIDTH, 1023));
    rows.push_back(reg_row(REG_FRAME_HEIGHT, 1023));
    rows.push_back(reg_row(REG_SHEET_COLUMNS, 255));
    rows.push_back(reg_row(REG_FIRST_FRAME, 0));
    rows.push_back(reg_row(REG_LAST_FRAME, 255));
    rows.push_back(reg_row(REG_FRAME_PERIOD, 0));
    rows.push_back(pinned_row(KIND_TICK, 0, 0, 0, 0, 0, 0, 1023, 1023));
    rows.push_back(pinned_row(KIND_TICK, 1, 0, 1, 1, 0, 1023, 1023, 2046));
    rows.push_back(pinned_row(KIND_SET, 0, 255, 255, 0, 0, 1023, 1023, 2046));
    rows.push_back(pinned_row(KIND_TICK, 1023, 0, 0, 1, 0, 0, 1023, 1023));
    rows.push_back(pinned_row(KIND_SET, 0, 254, 254, 0, 0, 0, 1023, 1023));
    rows.push_back(pinned_row(KIND_TICK, 1, 0, 255, 1, 1023, 0, 2046, 1023));
    // zero columns, ping-pong with the range pinned at the top frame
    rows.push_back(reg_row(REG_SHEET_COLUMNS, 0));
    rows.push_back(reg_row(REG_PING_PONG, 1));
    rows.push_back(reg_row(REG_FIRST_FRAME, 255));
    rows.push_back(item_row(KIND_TICK, 5, 0));
    rows.push_back(item_row(KIND_TICK, 5, 0));
    // small bounce range, set-frame below, above and inside it
    rows.push_back(reg_row(REG_FIRST_FRAME, 3));
    rows.push_back(reg_row(REG_LAST_FRAME, 6));
    rows.push_back(reg_row(REG_FRAME_WIDTH, 1));
    rows.push_back(reg_row(REG_FRAME_HEIGHT, 1));
    rows.push_back(reg_row(REG_FRAME_PERIOD, 10));
    rows.push_back(item_row(KIND_SET, 0, 2));
    rows.push_back(item_row(KIND_SET, 0, 7));
    rows.push_back(item_row(KIND_SET, 0, 4));
    repeat (6) rows.push_back(item_row(KIND_TICK, 11, 0));
    rows.push_back(item_row(KIND_TICK, 10, 0));
    rows.push_back(item_row(KIND_TICK, 1, 0));
    rows.push_back(item_row(KIND_RESTART, 0, 0));

    foreach (rows[i]) begin
      if (rows[i].row == ROW_REG) begin
        drain_results();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_item(rows[i]);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          width_v = 1; height_v = 1; cols_v = 1;
          first_v = 0; last_v = 0; period_v = 0; pp_v = 0;
        end
        1: begin
          width_v = 1023; height_v = 1023; cols_v = 255;
          first_v = 255; last_v = 255; period_v = 65535; pp_v = 1;
        end
        2: begin
          width_v = 1023; height_v = 1023; cols_v = 1;
          first_v = 0; last_v = 255; period_v = 0; pp_v = 1;
        end
        3: begin
          width_v = 7; height_v = 9; cols_v = 255;
          first_v = 0; last_v = 255; period_v = 3; pp_v = 0;
        end
        default: begin
          width_v  = $urandom_range(1, 1023);
          height_v = $urandom_range(1, 1023);
          cols_v   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 8);
          first_v  = $urandom_range(0, 255);
          span     = (255 - first_v > 12) ? 12 : 255 - first_v;
          last_v   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                 : first_v + $urandom_range(0, span);
          period_v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 1500);
          pp_v     = $urandom_range(0, 1);
        end
      endcase
      drain_results();
      write_reg(REG_FRAME_WIDTH, CFG_W'(width_v));
      write_reg(REG_FRAME_HEIGHT, CFG_W'(height_v));
      write_reg(REG_SHEET_COLUMNS, CFG_W'(cols_v));
      write_reg(REG_FIRST_FRAME, CFG_W'(first_v));
      write_reg(REG_LAST_FRAME, CFG_W'(last_v));
      write_reg(REG_FRAME_PERIOD, CFG_W'(period_v));
      write_reg(REG_PING_PONG, CFG_W'(pp_v));

      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 70)      k = KIND_TICK;
        else if (r < 85) k = KIND_SET;
        else if (r < 93) k = KIND_RESTART;
        else             k = KIND_UNUSED;
        case ($urandom_range(0, 9))
          0:       ms = 0;
          1:       ms = 1023;
          default: ms = $urandom_range(0, 1023);
        endcase
        if (first_v <= last_v && $urandom_range(0, 3) != 0)
          idx = $urandom_range(first_v, last_v);
        else
          idx = $urandom_range(0, 255);
        s = item_row(k, ELAPSED_W'(ms), FRAME_W'(idx));
        send_item(s);
      end
    end

    drain_results();
    if (mismatch_cnt == 0 && frame_rect_q.size() == 0) begin
      $display("** sprite_frame_sequencer_top: PASSED **");
    end else begin
      $display("** sprite_frame_sequencer_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("** sprite_frame_sequencer_top: FAILED **");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/spfs_pkg.sv
hdl/sprite_frame_sequencer_top.sv
hdl/spfs_checker.sv
test/sprite_frame_sequencer_top_tb.sv
